// ===== design/inverse_distance_interpolator_macros.svh =====
// Assertion macros shared by the interpolator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef INVERSE_DISTANCE_INTERPOLATOR_MACROS_SVH
`define INVERSE_DISTANCE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define IDI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interpolator check failed");

// Next-cycle implication.
`define IDI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interpolator check failed");

`endif

// ===== design/idi_pkg.sv =====
// Shared types and constants of the inverse distance interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package idi_pkg;

    localparam int IO_COMPS     = 4;   // vector components on the streams
    localparam int COORD_W      = 24;  // Q16.8 coordinate
    localparam int VAL_W        = 32;  // Q16.16 component
    localparam int DIFF_W       = 25;  // coordinate difference
    localparam int D2_W         = 50;  // squared distance
    localparam int WGT_W        = 25;  // weight, at most 2^24
    localparam int MUL_A_W      = 33;
    localparam int MUL_B_W      = 26;
    localparam int PROD_W       = 59;
    localparam int WEIGHT_STEPS = 41;  // quotient bits of 2^40 / d2

    localparam logic [D2_W-1:0] SNAP_D2   = D2_W'(65536);
    localparam int              DEN_FLOOR = 17;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_RD     = 13'b0000000000010,
        ST_DX     = 13'b0000000000100,
        ST_SQX    = 13'b0000000001000,
        ST_SQY    = 13'b0000000010000,
        ST_D2     = 13'b0000000100000,
        ST_SNAP   = 13'b0000001000000,
        ST_WDIV   = 13'b0000010000000,
        ST_MUL    = 13'b0000100000000,
        ST_ACC    = 13'b0001000000000,
        ST_FSTART = 13'b0010000000000,
        ST_FDIV   = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } state_t;

endpackage

`default_nettype wire

// ===== design/idi_store.sv =====
// Sample point store: coordinate memory and vector memory, one read port each.
// Depends on idi_pkg for field widths.
`default_nettype none

module idi_store
    import idi_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ROW_W  = 128,
    parameter int ADDR_W = 6
)
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [2*COORD_W-1:0] wr_pos,
    input  wire logic [ROW_W-1:0]     wr_row,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output logic      [2*COORD_W-1:0] rd_pos,
    output logic      [ROW_W-1:0]     rd_row
);

    logic [2*COORD_W-1:0] pos_mem [DEPTH];
    logic [ROW_W-1:0]     row_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_addr] <= wr_pos;
            row_mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_pos <= pos_mem[rd_addr];
            rd_row <= row_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/idi_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by weights and results.
// Depends on idi_pkg only by convention of the block.
`default_nettype none

module idi_divider
    import idi_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 50,
    parameter int CNT_W = 7
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num_in,    // dividend, processed from its top bit
    input  wire logic [DEN_W-1:0] den_in,
    input  wire logic [CNT_W-1:0] steps_in,
    output logic                  busy,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps_in;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num_in;
            den_reg <= den_in;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ===== design/inverse_distance_interpolator.sv =====
// Inverse distance interpolator. Requests on the input stream clear the point
// store, add a sample point, or query a position; only a query yields a result
// request. A query reads the stored points one at a time from the store memory
// and, for each point, forms the squared distance with a shared multiplier and
// takes its weight 2^40 / d2 on a bit-serial divider. The query then runs one
// final division of ACC_W quotient bits per component in use, ACC_W being
// 59 + log2(MAX_POINTS). A query that meets a point closer than 1.0 stops there
// and returns that point's vector. The output is a register, so new requests
// are taken while a result waits.
// Depends on idi_pkg, idi_store, idi_divider and the assertion macro header.
`default_nettype none

`include "inverse_distance_interpolator_macros.svh"

module inverse_distance_interpolator
    import idi_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COMPONENTS = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x[23:0], pos_y[47:24], sample_c0..sample_c3 in 32-bit slices from 48
    input  wire logic [175:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_c0..result_c3, 32 bits each from bit 0
    output logic      [127:0] m_tdata,
    // snapped[0], store_empty[1]
    output logic      [1:0]   m_tuser,
    input  wire logic         cfg_we,
    // components_used[2:0]
    input  wire logic [2:0]   cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ROW_W  = COMPONENTS * VAL_W;
    localparam int IO_N   = (COMPONENTS < IO_COMPS) ? COMPONENTS : IO_COMPS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_POINTS);
    localparam int DEN_W  = WGT_W + $clog2(MAX_POINTS);
    localparam int DV_W   = (D2_W > DEN_W) ? D2_W : DEN_W;
    localparam int DC_W   = $clog2(ACC_W + 1);

    // Control state.
    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [2:0]        k_reg;
    logic [2:0]        cfg_reg;
    logic              m_valid_reg;

    // Datapath.
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [VAL_W-1:0]          vals_reg [IO_COMPS];
    logic [D2_W-1:0]           d2_reg;
    logic [WGT_W-1:0]          w_reg;
    logic [DEN_W-1:0]          den_reg;
    logic signed [ACC_W-1:0]   acc_reg [IO_COMPS];
    logic [VAL_W-1:0]          res_reg [IO_COMPS];
    logic                      snap_reg, empty_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [127:0]              out_data_reg;
    logic [1:0]                out_user_reg;

    logic                      s_fire;
    logic [2:0]                nc;
    logic                      last_point;
    logic                      is_snap;
    logic [DEN_W-1:0]          den_eff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   acc_sel;
    logic [ACC_W-1:0]          acc_mag;
    logic [VAL_W-1:0]          sat_val;

    // Store ports.
    logic                 st_wr_en;
    logic [ROW_W-1:0]     st_wr_row;
    logic [2*COORD_W-1:0] st_rd_pos;
    logic [ROW_W-1:0]     st_rd_row;

    // Divider ports.
    logic                 div_start;
    logic [ACC_W-1:0]     div_num;
    logic [DV_W-1:0]      div_den;
    logic [DC_W-1:0]      div_steps;
    logic                 div_busy, div_done;
    logic [ACC_W-1:0]     div_quot;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign nc       = (cfg_reg > 3'(IO_N)) ? 3'(IO_N) : cfg_reg;
    assign last_point = (i_reg == count_reg - 1'b1);
    assign is_snap  = (d2_reg < SNAP_D2);
    assign den_eff  = (den_reg < DEN_W'(DEN_FLOOR)) ? DEN_W'(DEN_FLOOR) : den_reg;

    // Store write row: components past the stream width are kept as zero.
    assign st_wr_en = s_fire && (s_tuser == OP_ADD) && (count_reg < CNT_W'(MAX_POINTS));
    for (genvar c = 0; c < COMPONENTS; c++)
    begin : g_wr_row
        if (c < IO_COMPS)
        begin : g_io
            assign st_wr_row[c*VAL_W +: VAL_W] = s_tdata[48 + c*VAL_W +: VAL_W];
        end
        else
        begin : g_pad
            assign st_wr_row[c*VAL_W +: VAL_W] = '0;
        end
    end

    idi_store #(
        .DEPTH  (MAX_POINTS),
        .ROW_W  (ROW_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_pos  (s_tdata[2*COORD_W-1:0]),
        .wr_row  (st_wr_row),
        .rd_en   (state_reg == ST_RD),
        .rd_addr (i_reg[ADDR_W-1:0]),
        .rd_pos  (st_rd_pos),
        .rd_row  (st_rd_row)
    );

    // The one multiplier: squares of the differences, then value times weight.
    always_comb
    begin
        case (state_reg)
            ST_SQX:
            begin
                mul_a = MUL_A_W'(dx_reg);
                mul_b = MUL_B_W'(dx_reg);
            end
            ST_SQY:
            begin
                mul_a = MUL_A_W'(dy_reg);
                mul_b = MUL_B_W'(dy_reg);
            end
            default:
            begin
                mul_a = MUL_A_W'($signed(vals_reg[k_reg[1:0]]));
                mul_b = $signed({1'b0, w_reg});
            end
        endcase
    end

    assign acc_sel = acc_reg[k_reg[1:0]];
    assign acc_mag = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);

    // The weight divides 2^40 by d2; a result divides |sum| by the weight sum.
    assign div_start = ((state_reg == ST_SNAP) && !is_snap) || (state_reg == ST_FSTART);
    assign div_num   = (state_reg == ST_SNAP) ? {1'b1, {(ACC_W-1){1'b0}}} : acc_mag;
    assign div_den   = (state_reg == ST_SNAP) ? DV_W'(d2_reg) : DV_W'(den_eff);
    assign div_steps = (state_reg == ST_SNAP) ? DC_W'(WEIGHT_STEPS) : DC_W'(ACC_W);

    idi_divider #(
        .NUM_W (ACC_W),
        .DEN_W (DV_W),
        .CNT_W (DC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_in   (div_num),
        .den_in   (div_den),
        .steps_in (div_steps),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Saturate the quotient to 32 signed bits, with the sign of the sum.
    always_comb
    begin
        if (acc_sel[ACC_W-1])
        begin
            if ((|div_quot[ACC_W-1:32]) || (div_quot[31] && (|div_quot[30:0])))
                sat_val = 32'h8000_0000;
            else
                sat_val = 32'(-div_quot[31:0]);
        end
        else
        begin
            if ((|div_quot[ACC_W-1:32]) || div_quot[31])
                sat_val = 32'h7FFF_FFFF;
            else
                sat_val = div_quot[31:0];
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            i_reg       <= '0;
            k_reg       <= '0;
            cfg_reg     <= 3'd4;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            // In the done state the output handshake is resolved below.
            if (m_valid_reg && m_tready && (state_reg != ST_DONE))
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        case (s_tuser)
                            OP_CLEAR: count_reg <= '0;
                            OP_ADD:
                            begin
                                if (count_reg < CNT_W'(MAX_POINTS))
                                    count_reg <= count_reg + 1'b1;
                            end
                            OP_QUERY:
                            begin
                                i_reg     <= '0;
                                state_reg <= (count_reg == '0) ? ST_DONE : ST_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RD:  state_reg <= ST_DX;
                ST_DX:  state_reg <= ST_SQX;
                ST_SQX: state_reg <= ST_SQY;
                ST_SQY: state_reg <= ST_D2;
                ST_D2:  state_reg <= ST_SNAP;
                ST_SNAP: state_reg <= is_snap ? ST_DONE : ST_WDIV;
                ST_WDIV:
                begin
                    if (div_done)
                    begin
                        k_reg <= '0;
                        if (nc != 3'd0)
                            state_reg <= ST_MUL;
                        else if (last_point)
                            state_reg <= ST_DONE;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (3'(k_reg + 3'd1) < nc)
                    begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= ST_MUL;
                    end
                    else if (last_point)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_FSTART;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_FSTART: state_reg <= ST_FDIV;
                ST_FDIV:
                begin
                    if (div_done)
                    begin
                        if (3'(k_reg + 3'd1) < nc)
                        begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= ST_FSTART;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a * mul_b);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_tuser == OP_QUERY))
                begin
                    px_reg    <= s_tdata[COORD_W-1:0];
                    py_reg    <= s_tdata[2*COORD_W-1:COORD_W];
                    den_reg   <= '0;
                    snap_reg  <= 1'b0;
                    empty_reg <= (count_reg == '0);
                    for (int c = 0; c < IO_COMPS; c++)
                    begin
                        acc_reg[c] <= '0;
                        res_reg[c] <= '0;
                    end
                end
            end
            ST_DX:
            begin
                dx_reg <= DIFF_W'($signed(st_rd_pos[COORD_W-1:0])) - DIFF_W'(px_reg);
                dy_reg <= DIFF_W'($signed(st_rd_pos[2*COORD_W-1:COORD_W])) - DIFF_W'(py_reg);
                for (int c = 0; c < IO_COMPS; c++)
                    vals_reg[c] <= (c < IO_N) ? st_rd_row[c*VAL_W +: VAL_W] : '0;
            end
            ST_SQY: d2_reg <= prod_reg[D2_W-1:0];
            ST_D2:  d2_reg <= d2_reg + prod_reg[D2_W-1:0];
            ST_SNAP:
            begin
                if (is_snap)
                begin
                    snap_reg <= 1'b1;
                    for (int c = 0; c < IO_COMPS; c++)
                        res_reg[c] <= (3'(c) < nc) ? vals_reg[c] : '0;
                end
            end
            ST_WDIV:
            begin
                if (div_done)
                begin
                    w_reg   <= div_quot[WGT_W-1:0];
                    den_reg <= den_reg + DEN_W'(div_quot[WGT_W-1:0]);
                end
            end
            ST_ACC:
                acc_reg[k_reg[1:0]] <= acc_sel + ACC_W'(prod_reg);
            ST_FDIV:
            begin
                if (div_done)
                    res_reg[k_reg[1:0]] <= sat_val;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_data_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                    out_user_reg <= {empty_reg, snap_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `IDI_ASSERT_IMP(a_flags_exclusive, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    `IDI_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_POINTS))
    `IDI_ASSERT_IMP(a_div_owner, div_busy, state_reg == ST_WDIV || state_reg == ST_FDIV)
    `IDI_ASSERT_NEXT(a_empty_query, s_fire && s_tuser == OP_QUERY && count_reg == '0, state_reg == ST_DONE)

endmodule

`default_nettype wire
